[design/kce_pkg.sv]
`timescale 1ns / 1ps

package kce_pkg;

    localparam int          CODE_DIGITS   = 6;
    localparam int          DIGIT_W       = 8;
    localparam int          COUNT_W       = 3;
    localparam int          TICK_W        = 32;
    localparam int          CODE_W        = CODE_DIGITS * DIGIT_W;

    localparam logic [DIGIT_W-1:0] KEY_NONE  = 8'd0;
    localparam logic [DIGIT_W-1:0] KEY_ERASE = 8'd35;
    localparam logic [DIGIT_W-1:0] KEY_ENTER = 8'd42;

    localparam logic [TICK_W-1:0]  TIMEOUT_RESET = 32'd5000;

    typedef enum logic [3:0] {
        MODE_WAIT_D1    = 4'd0,
        MODE_WAIT_D2    = 4'd1,
        MODE_WAIT_D3    = 4'd2,
        MODE_WAIT_D4    = 4'd3,
        MODE_WAIT_D5    = 4'd4,
        MODE_WAIT_D6    = 4'd5,
        MODE_CONFIRM    = 4'd6,
        MODE_SEND       = 4'd7,
        MODE_INCOMPLETE = 4'd8,
        MODE_TIMEOUT    = 4'd9
    } t_mode;

    typedef enum logic [2:0] {
        MSG_IDLE       = 3'd0,
        MSG_START      = 3'd1,
        MSG_DIGIT      = 3'd2,
        MSG_ERASE      = 3'd3,
        MSG_INCOMPLETE = 3'd4,
        MSG_TIMEOUT    = 3'd5
    } t_msg;

    typedef struct packed {
        logic                 wr_en;
        logic [COUNT_W-1:0]   wr_idx;
        logic [DIGIT_W-1:0]   wr_data;
        logic                 clear;
    } t_store_cmd;

endpackage

[design/kce_store.sv]
`timescale 1ns / 1ps

module kce_store (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_advance,
    input  kce_pkg::t_store_cmd                 i_cmd,
    input  logic [kce_pkg::COUNT_W-1:0]         i_count,
    output logic [kce_pkg::CODE_W-1:0]          o_code
);

    logic [kce_pkg::DIGIT_W-1:0] r_digit [kce_pkg::CODE_DIGITS];
    logic [kce_pkg::DIGIT_W-1:0] n_digit [kce_pkg::CODE_DIGITS];

    always_comb begin
        for (int i = 0; i < kce_pkg::CODE_DIGITS; i++) begin
            n_digit[i] = r_digit[i];
            if (i_cmd.clear) begin
                n_digit[i] = '0;
            end else if (i_cmd.wr_en && (i_cmd.wr_idx == kce_pkg::COUNT_W'(i))) begin
                n_digit[i] = i_cmd.wr_data;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < kce_pkg::CODE_DIGITS; i++) begin
            if (kce_pkg::COUNT_W'(i) < i_count) begin
                o_code[i*kce_pkg::DIGIT_W +: kce_pkg::DIGIT_W] = n_digit[i];
            end else begin
                o_code[i*kce_pkg::DIGIT_W +: kce_pkg::DIGIT_W] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < kce_pkg::CODE_DIGITS; i++) begin
                r_digit[i] <= '0;
            end
        end else if (i_advance) begin
            for (int i = 0; i < kce_pkg::CODE_DIGITS; i++) begin
                r_digit[i] <= n_digit[i];
            end
        end
    end

endmodule

[design/kce_ctrl.sv]
`timescale 1ns / 1ps

module kce_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_advance,
    input  logic [kce_pkg::DIGIT_W-1:0]         i_key,
    input  logic [kce_pkg::TICK_W-1:0]          i_now_ticks,
    input  logic [kce_pkg::TICK_W-1:0]          i_timeout_ticks,
    output kce_pkg::t_store_cmd                 o_cmd,
    output kce_pkg::t_msg                       o_message,
    output logic                                o_send,
    output logic [kce_pkg::COUNT_W-1:0]         o_code_length
);

    kce_pkg::t_mode                  r_mode;
    kce_pkg::t_mode                  n_mode;
    logic [kce_pkg::COUNT_W-1:0]     r_count;
    logic [kce_pkg::COUNT_W-1:0]     n_count;
    logic [kce_pkg::TICK_W-1:0]      r_last_time;
    logic [kce_pkg::TICK_W-1:0]      n_last_time;

    logic                            key_none;
    logic                            key_erase;
    logic                            key_enter;
    logic                            key_digit;
    logic                            in_time;
    logic                            has_room;
    logic [kce_pkg::TICK_W-1:0]      elapsed;

    assign key_none  = (i_key == kce_pkg::KEY_NONE);
    assign key_erase = (i_key == kce_pkg::KEY_ERASE);
    assign key_enter = (i_key == kce_pkg::KEY_ENTER);
    assign key_digit = !key_none && !key_erase && !key_enter;
    assign elapsed   = i_now_ticks - r_last_time;
    assign in_time   = (elapsed < i_timeout_ticks);
    assign has_room  = (r_count < kce_pkg::COUNT_W'(kce_pkg::CODE_DIGITS));

    always_comb begin
        n_mode      = r_mode;
        n_count     = r_count;
        n_last_time = r_last_time;
        case (r_mode)
            kce_pkg::MODE_WAIT_D1: begin
                if (key_digit) begin
                    n_mode      = kce_pkg::MODE_WAIT_D2;
                    n_count     = kce_pkg::COUNT_W'(1);
                    n_last_time = i_now_ticks;
                end
            end
            kce_pkg::MODE_WAIT_D2, kce_pkg::MODE_WAIT_D3, kce_pkg::MODE_WAIT_D4,
            kce_pkg::MODE_WAIT_D5, kce_pkg::MODE_WAIT_D6, kce_pkg::MODE_CONFIRM: begin
                if (!in_time) begin
                    n_mode = kce_pkg::MODE_TIMEOUT;
                end else if (key_erase) begin
                    if (r_count != '0) begin
                        n_count     = r_count - kce_pkg::COUNT_W'(1);
                        n_last_time = i_now_ticks;
                        n_mode      = kce_pkg::t_mode'(r_mode - 4'd1);
                    end
                end else if (key_enter) begin
                    if (r_mode == kce_pkg::MODE_CONFIRM) begin
                        n_mode = kce_pkg::MODE_SEND;
                    end else begin
                        n_mode = kce_pkg::MODE_INCOMPLETE;
                    end
                end else if (key_digit && has_room) begin
                    n_count     = r_count + kce_pkg::COUNT_W'(1);
                    n_last_time = i_now_ticks;
                    if (r_mode != kce_pkg::MODE_CONFIRM) begin
                        n_mode = kce_pkg::t_mode'(r_mode + 4'd1);
                    end
                end
            end
            kce_pkg::MODE_SEND: begin
                n_mode  = kce_pkg::MODE_WAIT_D1;
                n_count = '0;
            end
            default: begin
                n_mode  = kce_pkg::MODE_WAIT_D1;
                n_count = '0;
            end
        endcase
    end

    always_comb begin
        o_message     = kce_pkg::MSG_IDLE;
        o_send        = 1'b0;
        o_cmd         = '0;
        o_code_length = n_count;
        case (r_mode)
            kce_pkg::MODE_WAIT_D1: begin
                if (key_digit) begin
                    o_message     = kce_pkg::MSG_DIGIT;
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_idx  = '0;
                    o_cmd.wr_data = i_key;
                end else begin
                    o_message = kce_pkg::MSG_START;
                end
            end
            kce_pkg::MODE_WAIT_D2, kce_pkg::MODE_WAIT_D3, kce_pkg::MODE_WAIT_D4,
            kce_pkg::MODE_WAIT_D5, kce_pkg::MODE_WAIT_D6, kce_pkg::MODE_CONFIRM: begin
                if (!in_time) begin
                    o_message = kce_pkg::MSG_TIMEOUT;
                end else if (key_erase) begin
                    if (r_count != '0) begin
                        o_message     = kce_pkg::MSG_ERASE;
                        o_cmd.wr_en   = 1'b1;
                        o_cmd.wr_idx  = r_count - kce_pkg::COUNT_W'(1);
                        o_cmd.wr_data = '0;
                    end
                end else if (key_enter) begin
                    if (r_mode != kce_pkg::MODE_CONFIRM) begin
                        o_message = kce_pkg::MSG_INCOMPLETE;
                    end
                end else if (key_digit && has_room) begin
                    o_message     = kce_pkg::MSG_DIGIT;
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_idx  = r_count;
                    o_cmd.wr_data = i_key;
                end
            end
            kce_pkg::MODE_SEND: begin
                o_send        = 1'b1;
                o_code_length = r_count;
            end
            default: begin
                o_message   = kce_pkg::MSG_START;
                o_cmd.clear = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= kce_pkg::MODE_WAIT_D1;
            r_count     <= '0;
            r_last_time <= '0;
        end else if (i_advance) begin
            r_mode      <= n_mode;
            r_count     <= n_count;
            r_last_time <= n_last_time;
        end
    end

endmodule

[design/keypad_code_entry_fsm_core.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake                   Payload
// poll      in         i_valid / o_ready           i_key, i_now_ticks
// result    out        o_valid / i_ready           o_message, o_send, o_entered_code,
//                                                  o_code_length
// config    in         i_cfg_valid / o_cfg_ready   i_cfg_timeout_ticks
//
// One poll per cycle sustained unless the result stalls; a beat passes the poll register, then the result register.
// The poll register feeds the mode/count/digit update and the result register in one pass.
// A stalled result holds the result register; the poll register still takes one more beat.
// Reset: mode waits for the first digit, digits and counts clear, timeout returns to 5000.
// The config port is always ready.

module keypad_code_entry_fsm_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [kce_pkg::DIGIT_W-1:0]         i_key,
    input  logic [kce_pkg::TICK_W-1:0]          i_now_ticks,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [2:0]                          o_message,
    output logic                                o_send,
    output logic [kce_pkg::CODE_W-1:0]          o_entered_code,
    output logic [kce_pkg::COUNT_W-1:0]         o_code_length,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [kce_pkg::TICK_W-1:0]          i_cfg_timeout_ticks
);

    logic                            r_in_vld;
    logic [kce_pkg::DIGIT_W-1:0]     r_key;
    logic [kce_pkg::TICK_W-1:0]      r_now;
    logic [kce_pkg::TICK_W-1:0]      r_timeout;

    logic                            r_out_vld;
    kce_pkg::t_msg                   r_msg;
    logic                            r_send;
    logic [kce_pkg::CODE_W-1:0]      r_code;
    logic [kce_pkg::COUNT_W-1:0]     r_len;

    logic                            advance;
    kce_pkg::t_store_cmd             store_cmd;
    kce_pkg::t_msg                   msg;
    logic                            send;
    logic [kce_pkg::COUNT_W-1:0]     len;
    logic [kce_pkg::CODE_W-1:0]      code;

    assign advance     = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready     = !r_in_vld || advance;
    assign o_cfg_ready = 1'b1;

    kce_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_advance       (advance),
        .i_key           (r_key),
        .i_now_ticks     (r_now),
        .i_timeout_ticks (r_timeout),
        .o_cmd           (store_cmd),
        .o_message       (msg),
        .o_send          (send),
        .o_code_length   (len)
    );

    kce_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_cmd     (store_cmd),
        .i_count   (len),
        .o_code    (code)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= kce_pkg::TIMEOUT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_timeout <= i_cfg_timeout_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_key <= i_key;
            r_now <= i_now_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_msg  <= msg;
            r_send <= send;
            r_code <= code;
            r_len  <= len;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_message      = r_msg;
    assign o_send         = r_send;
    assign o_entered_code = r_code;
    assign o_code_length  = r_len;

endmodule

[design/kce_checker.sv]
`timescale 1ns / 1ps

module kce_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_valid,
    input  logic                                i_ready,
    input  logic [2:0]                          o_message,
    input  logic                                o_send,
    input  logic [kce_pkg::CODE_W-1:0]          o_entered_code,
    input  logic [kce_pkg::COUNT_W-1:0]         o_code_length
);

    a_send_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_send) |->
            (o_message == kce_pkg::MSG_IDLE) &&
            (o_code_length == kce_pkg::COUNT_W'(kce_pkg::CODE_DIGITS)))
        else $error("send without a full code");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_code_length <= kce_pkg::COUNT_W'(kce_pkg::CODE_DIGITS)))
        else $error("code length out of range");

    a_empty_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_code_length == '0)) |-> (o_entered_code == '0))
        else $error("digits shown with zero length");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_entered_code) &&
            $stable(o_message) && $stable(o_send) && $stable(o_code_length)))
        else $error("stalled result changed");

endmodule

bind keypad_code_entry_fsm_core kce_checker u_kce_checker (.*);
